>>> src/dcn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dcn_pkg;

  // field widths
  localparam int DEPTH_W  = 8;
  localparam int HESS_W   = 11;  // hxx, hyy, trace, difference
  localparam int H2_W     = 9;   // twice the cross term
  localparam int GRAD_W   = 9;   // central differences
  localparam int DIR_W    = 13;
  localparam int Z_W      = 21;
  localparam int CURV_W   = 20;
  localparam int THR_W    = 20;
  localparam int PIX_W    = 8;

  // square root unit
  localparam int DISC_W      = 22;
  localparam int ROOT_W      = DISC_W / 2;
  localparam int SQRT_STAGES = 3;

  localparam int FRAC_BITS_DEFAULT = 8;

  // configuration port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_THR  = 1'b0;  // register index taken from paddr[2]
  localparam logic [THR_W-1:0] THR_RESET = 20'd256;

  // hessian terms carried down the pipeline
  typedef struct packed {
    logic signed [HESS_W-1:0] hxx;
    logic signed [HESS_W-1:0] tr;
    logic signed [HESS_W-1:0] df;
    logic signed [H2_W-1:0]   h2;
    logic signed [GRAD_W-1:0] dx;
    logic signed [GRAD_W-1:0] dy;
    logic                     umb;
    logic                     border;
    logic [PIX_W-1:0]         pix;
  } hess_t;

endpackage

`default_nettype wire

>>> src/depth_curvature_normal_3x3.sv
`timescale 1ns / 1ps
`default_nettype none

// channel      | direction | handshake          | contents
// -------------+-----------+--------------------+---------------------------------------
// item in      | in        | start, busy        | 3x3 depths, at_border, center_value
// result out   | out       | done (one cycle)   | curvatures, directions, normal, flag
// config       | in/out    | apb psel/penable   | distinct_threshold at byte address 0
//
// one word enters per clock; busy is always low since nothing stalls
// a result is registered after each step in turn: hessian, discriminant multiply,
//   three square root stages (four, four and three root digits), eigen step, lift and output
// rst clears the valid chain and sets the threshold to 256; data registers are not reset
// the receiver cannot hold a result off, so the pipeline never stops

module depth_curvature_normal_3x3 #(
  parameter int FRAC_BITS = dcn_pkg::FRAC_BITS_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // item in
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [dcn_pkg::DEPTH_W-1:0]       depth_nw,
  input  wire logic [dcn_pkg::DEPTH_W-1:0]       depth_n,
  input  wire logic [dcn_pkg::DEPTH_W-1:0]       depth_ne,
  input  wire logic [dcn_pkg::DEPTH_W-1:0]       depth_w,
  input  wire logic [dcn_pkg::DEPTH_W-1:0]       depth_c,
  input  wire logic [dcn_pkg::DEPTH_W-1:0]       depth_e,
  input  wire logic [dcn_pkg::DEPTH_W-1:0]       depth_sw,
  input  wire logic [dcn_pkg::DEPTH_W-1:0]       depth_s,
  input  wire logic [dcn_pkg::DEPTH_W-1:0]       depth_se,
  input  wire logic                              at_border,
  input  wire logic [dcn_pkg::PIX_W-1:0]         center_value,
  // result out
  output logic                                   done,
  output logic signed [dcn_pkg::CURV_W-1:0]      curv_first,
  output logic signed [dcn_pkg::CURV_W-1:0]      curv_second,
  output logic signed [dcn_pkg::DIR_W-1:0]       dir1_x,
  output logic signed [dcn_pkg::DIR_W-1:0]       dir1_y,
  output logic signed [dcn_pkg::Z_W-1:0]         dir1_z,
  output logic signed [dcn_pkg::DIR_W-1:0]       dir2_x,
  output logic signed [dcn_pkg::DIR_W-1:0]       dir2_y,
  output logic signed [dcn_pkg::Z_W-1:0]         dir2_z,
  output logic signed [dcn_pkg::GRAD_W-1:0]      normal_x,
  output logic signed [dcn_pkg::GRAD_W-1:0]      normal_y,
  output logic                                   fully_defined,
  output logic [dcn_pkg::PIX_W-1:0]              pixel_value,
  // config
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [dcn_pkg::APB_ADDR_W-1:0]    paddr,
  input  wire logic [dcn_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [dcn_pkg::APB_DATA_W-1:0]         prdata,
  output logic                                   pready
);

  localparam int NST  = dcn_pkg::SQRT_STAGES;
  localparam int LAT  = NST + 4;
  localparam int KW   = 13 + FRAC_BITS;                    // unsaturated curvature
  localparam int SW   = ((KW > dcn_pkg::CURV_W) ? KW : dcn_pkg::CURV_W) + 1;
  localparam int CW   = ((KW + 1 > dcn_pkg::THR_W) ? KW + 1 : dcn_pkg::THR_W) + 1;
  localparam int DW   = dcn_pkg::DIR_W;
  localparam int HW   = dcn_pkg::HESS_W;
  localparam int PW   = DW + dcn_pkg::GRAD_W;              // lift product width

  localparam logic signed [SW-1:0] CMAX = SW'(524287);
  localparam logic signed [SW-1:0] CMIN = -SW'(524288);

  // ---------------------------------------------------------------------------
  // configuration register
  // ---------------------------------------------------------------------------
  logic [dcn_pkg::THR_W-1:0] thr;
  logic                      wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == dcn_pkg::REG_THR);

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= dcn_pkg::THR_RESET;
    end else if (wr_en) begin
      thr <= pwdata[dcn_pkg::THR_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == dcn_pkg::REG_THR) begin
      prdata = dcn_pkg::APB_DATA_W'(thr);
    end
  end

  // ---------------------------------------------------------------------------
  // valid chain: one bit per stage, never stalls
  // ---------------------------------------------------------------------------
  logic           accept;
  logic [LAT-1:0] vld;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], accept};
    end
  end

  assign done = vld[LAT-1];

  // ---------------------------------------------------------------------------
  // stage 1: finite-difference hessian and central differences
  // ---------------------------------------------------------------------------
  logic signed [11:0] hxx_w, hyy_w, n4, n4_adj, hxy_w;
  logic signed [11:0] tr_w, df_w;
  dcn_pkg::hess_t     s1_d, s1, s2;

  always_comb begin
    hxx_w  = $signed({4'b0, depth_e}) + $signed({4'b0, depth_w})
           - $signed({3'b0, depth_c, 1'b0});
    hyy_w  = $signed({4'b0, depth_s}) + $signed({4'b0, depth_n})
           - $signed({3'b0, depth_c, 1'b0});
    n4     = $signed({4'b0, depth_se}) - $signed({4'b0, depth_sw})
           - $signed({4'b0, depth_ne}) + $signed({4'b0, depth_nw});
    // cross term divided by four, rounded toward zero
    n4_adj = n4 + $signed({10'b0, n4[11], n4[11]});
    hxy_w  = n4_adj >>> 2;
    tr_w   = hxx_w + hyy_w;
    df_w   = hyy_w - hxx_w;

    s1_d.hxx    = hxx_w[HW-1:0];
    s1_d.tr     = tr_w[HW-1:0];
    s1_d.df     = df_w[HW-1:0];
    s1_d.h2     = {hxy_w[dcn_pkg::H2_W-2:0], 1'b0};
    s1_d.dx     = $signed({1'b0, depth_e}) - $signed({1'b0, depth_w});
    s1_d.dy     = $signed({1'b0, depth_s}) - $signed({1'b0, depth_n});
    s1_d.umb    = (df_w == 12'sd0) && (hxy_w == 12'sd0);
    s1_d.border = at_border;
    s1_d.pix    = center_value;
  end

  always_ff @(posedge clk) begin
    s1 <= s1_d;
  end

  // ---------------------------------------------------------------------------
  // stage 2: discriminant (hyy - hxx)^2 + (2 hxy)^2
  // ---------------------------------------------------------------------------
  logic signed [dcn_pkg::DISC_W-1:0] sq_a, sq_b;
  logic        [dcn_pkg::DISC_W-1:0] disc;

  assign sq_a = s1.df * s1.df;
  assign sq_b = s1.h2 * s1.h2;

  always_ff @(posedge clk) begin
    s2   <= s1;
    disc <= sq_a + sq_b;
  end

  // ---------------------------------------------------------------------------
  // stages 3..5: square root, terms delayed alongside
  // ---------------------------------------------------------------------------
  logic [dcn_pkg::ROOT_W-1:0] rt;
  dcn_pkg::hess_t             hd [NST];

  dcn_isqrt u_isqrt (
    .clk   (clk),
    .value (disc),
    .root  (rt)
  );

  always_ff @(posedge clk) begin
    hd[0] <= s2;
    for (int i = 1; i < NST; i++) begin
      hd[i] <= hd[i-1];
    end
  end

  // ---------------------------------------------------------------------------
  // stage 6: eigenvalues and first eigenvector
  // ---------------------------------------------------------------------------
  dcn_pkg::hess_t        h6;
  logic signed [12:0]    sp, sm, rt_s;
  logic signed [KW-1:0]  k1_d, k2_d, k1, k2;
  logic signed [DW-1:0]  ax_d, ay_d, ax, ay;

  // (s << FRAC_BITS) / 2, rounded toward zero
  function automatic logic signed [KW-1:0] half_scaled(input logic signed [12:0] s);
    logic signed [KW-1:0] p;
    p = KW'(s) <<< FRAC_BITS;
    return (p + $signed({{(KW-1){1'b0}}, p[KW-1]})) >>> 1;
  endfunction

  always_comb begin
    h6   = hd[NST-1];
    rt_s = $signed({2'b0, rt});
    sp   = 13'(h6.tr) + rt_s;
    sm   = 13'(h6.tr) - rt_s;
    if (h6.umb) begin
      // umbilic point: both curvatures equal, axis-aligned directions
      k1_d = KW'(h6.hxx) <<< FRAC_BITS;
      k2_d = KW'(h6.hxx) <<< FRAC_BITS;
      ax_d = DW'(1);
      ay_d = '0;
    end else begin
      k1_d = half_scaled(sp);
      k2_d = half_scaled(sm);
      ax_d = DW'(h6.h2);
      ay_d = 13'(h6.df) + rt_s;
      // degenerate eigenvector: take the other form
      if (ax_d == '0 && ay_d == '0) begin
        ax_d = 13'(h6.df) - rt_s;
        ay_d = -DW'(h6.h2);
      end
    end
  end

  dcn_pkg::hess_t s6;

  always_ff @(posedge clk) begin
    s6 <= h6;
    k1 <= k1_d;
    k2 <= k2_d;
    ax <= ax_d;
    ay <= ay_d;
  end

  // ---------------------------------------------------------------------------
  // stage 7: lift to tangent plane, threshold, saturation, border defaults
  // ---------------------------------------------------------------------------
  logic signed [PW-1:0]  p_ax, p_ay, p_bx, p_by;
  logic signed [PW:0]    za_s, zb_s, za_h, zb_h;
  logic signed [DW-1:0]  bx;
  logic signed [KW:0]    gap;
  logic signed [CW-1:0]  gap_x, thr_x;
  logic signed [SW-1:0]  k1_x, k2_x;
  logic signed [dcn_pkg::CURV_W-1:0] k1_sat, k2_sat;

  always_comb begin
    bx    = -ay;
    p_ax  = ax * s6.dx;
    p_ay  = ay * s6.dy;
    p_bx  = bx * s6.dx;
    p_by  = ax * s6.dy;
    za_s  = PW'(p_ax) + (PW + 1)'(p_ay);
    zb_s  = (PW + 1)'(p_bx) + (PW + 1)'(p_by);
    za_h  = (za_s + $signed({{PW{1'b0}}, za_s[PW]})) >>> 1;
    zb_h  = (zb_s + $signed({{PW{1'b0}}, zb_s[PW]})) >>> 1;

    // gap is never negative: the root is never negative
    gap   = (KW + 1)'(k1) - (KW + 1)'(k2);
    gap_x = CW'(gap);
    thr_x = CW'($signed({1'b0, thr}));

    k1_x  = SW'(k1);
    k2_x  = SW'(k2);
    if (k1_x > CMAX) k1_sat = dcn_pkg::CURV_W'(CMAX);
    else if (k1_x < CMIN) k1_sat = dcn_pkg::CURV_W'(CMIN);
    else k1_sat = k1_x[dcn_pkg::CURV_W-1:0];
    if (k2_x > CMAX) k2_sat = dcn_pkg::CURV_W'(CMAX);
    else if (k2_x < CMIN) k2_sat = dcn_pkg::CURV_W'(CMIN);
    else k2_sat = k2_x[dcn_pkg::CURV_W-1:0];
  end

  always_ff @(posedge clk) begin
    pixel_value <= s6.pix;
    if (s6.border) begin
      curv_first    <= '0;
      curv_second   <= '0;
      dir1_x        <= DW'(1);
      dir1_y        <= '0;
      dir1_z        <= '0;
      dir2_x        <= '0;
      dir2_y        <= DW'(1);
      dir2_z        <= '0;
      normal_x      <= '0;
      normal_y      <= '0;
      fully_defined <= 1'b0;
    end else begin
      curv_first    <= k1_sat;
      curv_second   <= k2_sat;
      dir1_x        <= ax;
      dir1_y        <= ay;
      dir1_z        <= za_h[dcn_pkg::Z_W-1:0];
      dir2_x        <= bx;
      dir2_y        <= ax;
      dir2_z        <= zb_h[dcn_pkg::Z_W-1:0];
      normal_x      <= -s6.dx;
      normal_y      <= -s6.dy;
      fully_defined <= gap_x > thr_x;
    end
  end

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LAT))
    else $error("result without a word taken LAT cycles before");

  a_no_done_after_rst: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result strobe straight after reset");

  a_dir2_rot: assert property (@(posedge clk) disable iff (rst)
    done |-> (dir2_x == -dir1_y) && (dir2_y == dir1_x))
    else $error("second direction is not the first turned by a right angle");

  a_thr_hold: assert property (@(posedge clk) disable iff (rst)
    $past(!(psel && penable && pwrite)) |-> $stable(thr))
    else $error("threshold changed without a write");

endmodule

`default_nettype wire

>>> src/dcn_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none

// floor square root, digit by digit, spread over SQRT_STAGES register stages
module dcn_isqrt (
  input  wire logic                        clk,
  input  wire logic [dcn_pkg::DISC_W-1:0]  value,
  output logic      [dcn_pkg::ROOT_W-1:0]  root
);

  localparam int IN_W   = dcn_pkg::DISC_W;
  localparam int QW     = dcn_pkg::ROOT_W;
  localparam int NST    = dcn_pkg::SQRT_STAGES;
  localparam int PER    = (QW + NST - 1) / NST;
  localparam int RW     = QW + 1;
  localparam int TW     = RW + 2;

  logic [IN_W-1:0] val_q  [NST];
  logic [RW-1:0]   rem_q  [NST];
  logic [QW-1:0]   root_q [NST];

  for (genvar k = 0; k < NST; k++) begin : g_stage
    logic [IN_W-1:0] v_in;
    logic [RW-1:0]   r_in;
    logic [QW-1:0]   q_in;
    logic [IN_W-1:0] v;
    logic [RW-1:0]   r;
    logic [QW-1:0]   q;
    logic [TW-1:0]   r4;
    logic [TW-1:0]   t;
    logic [TW-1:0]   r4d;

    if (k == 0) begin : g_first
      assign v_in = value;
      assign r_in = '0;
      assign q_in = '0;
    end else begin : g_next
      assign v_in = val_q[k-1];
      assign r_in = rem_q[k-1];
      assign q_in = root_q[k-1];
    end

    always_comb begin
      v   = v_in;
      r   = r_in;
      q   = q_in;
      r4  = '0;
      t   = '0;
      r4d = '0;
      for (int j = 0; j < PER; j++) begin
        if (k * PER + j < QW) begin
          r4 = {r, v[IN_W-1 -: 2]};
          t  = TW'({q, 2'b01});
          r4d = r4 - t;
          if (r4 >= t) begin
            r = r4d[RW-1:0];
            q = {q[QW-2:0], 1'b1};
          end else begin
            r = r4[RW-1:0];
            q = {q[QW-2:0], 1'b0};
          end
          v = {v[IN_W-3:0], 2'b00};
        end
      end
    end

    always_ff @(posedge clk) begin
      val_q[k]  <= v;
      rem_q[k]  <= r;
      root_q[k] <= q;
    end
  end

  assign root = root_q[NST-1];

endmodule

`default_nettype wire
